// File: hdl/sacg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacg_pkg
// Shared types, constants and the arctangent table of the chain growth unit.
// ----------------------------------------------------------------------------
package sacg_pkg;

	localparam int MAX_SPHERES  = 1024;
	localparam int IDX_W        = $clog2(MAX_SPHERES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int CMP_W        = CNT_W + 11;
	localparam int CORDIC_STEPS = 17;
	localparam int STEP_W       = 5;
	localparam int INDEX_W      = 10;
	localparam int COORD_W      = 32;
	localparam int LEN_W        = 21;
	localparam int CLEN_W       = 10;
	localparam int NEAR_W       = 21;

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	typedef enum logic [0:0] {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_REJECT = 2'd1,
		ST_REFUSE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_BOND   = 2'd0,
		REG_RADIUS = 2'd1,
		REG_CHAIN  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic              vld;
		logic              flip;
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} cordic_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} pos_t;

	function automatic logic signed [32:0] atan_turn(input logic [STEP_W-1:0] i);
		logic signed [32:0] a;
		case (i)
			5'd0:    a = 33'sd536870912;
			5'd1:    a = 33'sd316933406;
			5'd2:    a = 33'sd167458907;
			5'd3:    a = 33'sd85004756;
			5'd4:    a = 33'sd42667331;
			5'd5:    a = 33'sd21354465;
			5'd6:    a = 33'sd10679838;
			5'd7:    a = 33'sd5340245;
			5'd8:    a = 33'sd2670163;
			5'd9:    a = 33'sd1335087;
			5'd10:   a = 33'sd667544;
			5'd11:   a = 33'sd333772;
			5'd12:   a = 33'sd166886;
			5'd13:   a = 33'sd83443;
			5'd14:   a = 33'sd41722;
			5'd15:   a = 33'sd20861;
			5'd16:   a = 33'sd10430;
			default: a = 33'sd0;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/sacg_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacg_cordic_cell
// One rotation-mode micro-rotation, registered, passed on to the next cell.
// ----------------------------------------------------------------------------
module sacg_cordic_cell
	import sacg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  cordic_t           din,
	output cordic_t           dout
);

	logic signed [32:0] xs;
	logic signed [32:0] ys;
	logic signed [32:0] at;
	cordic_t            nxt;

	always_comb begin
		xs       = din.x >>> step;
		ys       = din.y >>> step;
		at       = atan_turn(step);
		nxt      = din;
		if (!din.z[32]) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - at;
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end

endmodule

// File: hdl/sacg_cordic_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacg_cordic_chain
// Angle fold and a row of CORDIC cells giving cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module sacg_cordic_chain
	import sacg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_vld,
	input  logic [31:0]        angle,
	output logic               res_vld,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	cordic_t            link [CORDIC_STEPS+1];
	logic signed [32:0] za;
	logic signed [32:0] xo;
	logic signed [32:0] yo;

	always_comb begin
		za            = {angle[31], angle};
		link[0].vld   = angle_vld;
		link[0].flip  = 1'b0;
		link[0].x     = CORDIC_GAIN;
		link[0].y     = 33'sd0;
		link[0].z     = za;
		if (za > 33'sd1073741824) begin
			link[0].z    = za - 33'sd2147483648;
			link[0].flip = 1'b1;
		end else if (za < -33'sd1073741824) begin
			link[0].z    = za + 33'sd2147483648;
			link[0].flip = 1'b1;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		sacg_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP_W'(i)),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	always_comb begin
		xo      = link[CORDIC_STEPS].flip ? -link[CORDIC_STEPS].x : link[CORDIC_STEPS].x;
		yo      = link[CORDIC_STEPS].flip ? -link[CORDIC_STEPS].y : link[CORDIC_STEPS].y;
		res_vld = link[CORDIC_STEPS].vld;
		cos_val = xo[31:0];
		sin_val = yo[31:0];
	end

endmodule

// File: hdl/self_avoiding_chain_growth_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_avoiding_chain_growth_unit
// Grows a 3D hard-sphere chain one candidate per step transaction.
// ----------------------------------------------------------------------------
// Input stream: s_tuser is the opcode (start or step), s_tdata carries the
// two angles and the start position. Output stream: one result transaction
// per input, m_tuser the status, m_tlast set when the last required sphere
// was accepted. Registers bond_length, hard_radius and chain_length sit on
// the APB port at 0x0, 0x4 and 0x8.
// A start or a refused step goes from acceptance straight to the result stage,
// and the next transaction is taken once its result is loaded into the output
// register. A tried step passes through 2 angle issues into the 17-cell CORDIC
// row, two multiply stages, the add, one read of the sphere memory per stored
// sphere, the drain of the three-stage distance pipeline and the result stage.
// One item is in work at a time.
// Reset empties the chain and loads the register defaults; the sphere memory
// needs no clearing. A stalled receiver holds the result in the output
// register and the next item is taken meanwhile, then waits at the end.
// ----------------------------------------------------------------------------
module self_avoiding_chain_growth_unit
	import sacg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // azimuth, polar, start_x, start_y, start_z
	input  logic [0:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // sphere_index, pos_x, pos_y, pos_z, zero pad
	output logic [1:0]   m_tuser,   // status
	output logic         m_tlast,   // chain_done
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ANG   = 9'b000000010,
		S_WAIT  = 9'b000000100,
		S_MUL1  = 9'b000001000,
		S_MUL2  = 9'b000010000,
		S_ADD   = 9'b000100000,
		S_SCAN  = 9'b001000000,
		S_DRAIN = 9'b010000000,
		S_RES   = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    bond_q;
	logic [LEN_W-1:0]    radius_q;
	logic [CLEN_W-1:0]   clen_q;
	logic [CNT_W-1:0]    placed_q;
	logic [CNT_W-1:0]    scan_q;
	logic                got_az_q;
	logic [15:0]         polar_q;

	logic [CMP_W-1:0]    tsum;
	logic [CNT_W-1:0]    target;
	logic                accept;
	logic                cfg_wr;
	opcode_t             op;

	pos_t                mem [MAX_SPHERES];
	pos_t                rd_data_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	pos_t                mem_wd;

	logic                ang_vld;
	logic [31:0]         ang;
	logic                cor_vld;
	logic signed [31:0]  cor_cos;
	logic signed [31:0]  cor_sin;

	logic signed [31:0]  ct_q, st_q, cp_q, sp_q;
	logic signed [31:0]  ux_q, uy_q, uz_q;
	logic signed [31:0]  dx_q, dy_q, dz_q;
	pos_t                last_q;
	pos_t                cand_q;
	logic [2*LEN_W-1:0]  r2_q;
	logic signed [63:0]  pxy, pyy;
	logic signed [63:0]  qx, qy, qz;

	logic                rdv_q;
	logic signed [32:0]  ddx, ddy, ddz;
	logic [32:0]         adx, ady, adz;
	logic                v_s2, near_s2;
	logic [NEAR_W-1:0]   ax_s2, ay_s2, az_s2;
	logic                v_s3, near_s3;
	logic [2*NEAR_W-1:0] sx_s3, sy_s3, sz_s3;
	logic [2*NEAR_W+1:0] dsum;
	logic                hit_q;

	status_t             res_status_q;
	logic [INDEX_W-1:0]  res_index_q;
	pos_t                res_pos_q;
	logic                res_done_q;
	logic                commit_q;
	logic                out_load;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign op       = opcode_t'(s_tuser);
	assign tsum     = CMP_W'(clen_q) + CMP_W'(1);
	assign target   = (tsum > CMP_W'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES) : CNT_W'(tsum);
	assign out_load = (state_q == S_RES) && (!m_tvalid || m_tready);

	always_comb begin
		case (paddr[3:2])
			REG_BOND:   prdata = 32'(bond_q);
			REG_RADIUS: prdata = 32'(radius_q);
			REG_CHAIN:  prdata = 32'(clen_q);
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bond_q   <= LEN_W'(65536);
			radius_q <= LEN_W'(65536);
			clen_q   <= CLEN_W'(1023);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BOND:   bond_q   <= pwdata[LEN_W-1:0];
				REG_RADIUS: radius_q <= pwdata[LEN_W-1:0];
				REG_CHAIN:  clen_q   <= pwdata[CLEN_W-1:0];
				default:    ;
			endcase
		end
	end

	// sphere memory: one write port, one registered read port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = placed_q[IDX_W-1:0];
		mem_wd = res_pos_q;
		if (accept && op == OP_START) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = '{x: {16'd0, s_tdata[47:32]}, y: {16'd0, s_tdata[63:48]},
				z: {16'd0, s_tdata[79:64]}};
		end else if (out_load && commit_q) begin
			mem_we = 1'b1;
		end
		rd_addr = (state_q == S_SCAN) ? scan_q[IDX_W-1:0] : IDX_W'(placed_q - CNT_W'(1));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign ang_vld = (accept && op == OP_STEP && placed_q != '0 && placed_q < target)
		|| (state_q == S_ANG);
	assign ang     = (state_q == S_ANG) ? {1'b0, polar_q, 15'd0} : {s_tdata[15:0], 16'd0};

	sacg_cordic_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle_vld (ang_vld),
		.angle     (ang),
		.res_vld   (cor_vld),
		.cos_val   (cor_cos),
		.sin_val   (cor_sin)
	);

	assign pxy = sp_q * ct_q;
	assign pyy = sp_q * st_q;
	assign qx  = $signed({1'b0, bond_q}) * ux_q;
	assign qy  = $signed({1'b0, bond_q}) * uy_q;
	assign qz  = $signed({1'b0, bond_q}) * uz_q;

	always_comb begin
		ddx  = $signed({rd_data_q.x[31], rd_data_q.x}) - $signed({cand_q.x[31], cand_q.x});
		ddy  = $signed({rd_data_q.y[31], rd_data_q.y}) - $signed({cand_q.y[31], cand_q.y});
		ddz  = $signed({rd_data_q.z[31], rd_data_q.z}) - $signed({cand_q.z[31], cand_q.z});
		adx  = ddx[32] ? 33'(-ddx) : 33'(ddx);
		ady  = ddy[32] ? 33'(-ddy) : 33'(ddy);
		adz  = ddz[32] ? 33'(-ddz) : 33'(ddz);
		dsum = (2*NEAR_W+2)'(sx_s3) + (2*NEAR_W+2)'(sy_s3) + (2*NEAR_W+2)'(sz_s3);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) polar_q <= s_tdata[31:16];
		if (state_q == S_ANG) last_q <= rd_data_q;
		if (cor_vld && !got_az_q) begin
			ct_q <= cor_cos;
			st_q <= cor_sin;
		end
		if (cor_vld && got_az_q) begin
			cp_q <= cor_cos;
			sp_q <= cor_sin;
		end
		if (state_q == S_MUL1) begin
			ux_q <= pxy[61:30];
			uy_q <= pyy[61:30];
			uz_q <= cp_q;
			r2_q <= radius_q * radius_q;
		end
		if (state_q == S_MUL2) begin
			dx_q <= qx[61:30];
			dy_q <= qy[61:30];
			dz_q <= qz[61:30];
		end
		if (state_q == S_ADD) begin
			cand_q.x <= last_q.x + dx_q;
			cand_q.y <= last_q.y + dy_q;
			cand_q.z <= last_q.z + dz_q;
		end
		near_s2 <= (adx[32:NEAR_W] == '0) && (ady[32:NEAR_W] == '0) && (adz[32:NEAR_W] == '0);
		ax_s2   <= adx[NEAR_W-1:0];
		ay_s2   <= ady[NEAR_W-1:0];
		az_s2   <= adz[NEAR_W-1:0];
		near_s3 <= near_s2;
		sx_s3   <= ax_s2 * ax_s2;
		sy_s3   <= ay_s2 * ay_s2;
		sz_s3   <= az_s2 * az_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			placed_q     <= '0;
			scan_q       <= '0;
			got_az_q     <= 1'b0;
			rdv_q        <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			hit_q        <= 1'b0;
			commit_q     <= 1'b0;
			res_status_q <= ST_REFUSE;
			res_index_q  <= '0;
			res_pos_q    <= '0;
			res_done_q   <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tuser      <= '0;
			m_tdata      <= '0;
			m_tlast      <= 1'b0;
		end else begin
			rdv_q <= (state_q == S_SCAN);
			v_s2  <= rdv_q;
			v_s3  <= v_s2;
			if (v_s3 && near_s3 && ((2*NEAR_W+2)'(r2_q) > dsum)) hit_q <= 1'b1;
			if (cor_vld) got_az_q <= ~got_az_q;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						commit_q    <= 1'b0;
						res_index_q <= '0;
						if (op == OP_START) begin
							placed_q     <= CNT_W'(1);
							res_status_q <= ST_ACCEPT;
							res_pos_q    <= mem_wd;
							res_done_q   <= (target == CNT_W'(1));
							state_q      <= S_RES;
						end else if (placed_q == '0 || placed_q >= target) begin
							res_status_q <= ST_REFUSE;
							res_pos_q    <= '0;
							res_done_q   <= 1'b0;
							state_q      <= S_RES;
						end else begin
							state_q <= S_ANG;
						end
					end
				end
				S_ANG: state_q <= S_WAIT;
				S_WAIT: begin
					if (cor_vld && got_az_q) state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_ADD;
				S_ADD: begin
					scan_q  <= '0;
					hit_q   <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (scan_q == placed_q - CNT_W'(1)) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!rdv_q && !v_s2 && !v_s3) begin
						res_index_q  <= placed_q[INDEX_W-1:0];
						res_pos_q    <= cand_q;
						res_status_q <= hit_q ? ST_REJECT : ST_ACCEPT;
						commit_q     <= !hit_q;
						res_done_q   <= !hit_q && (placed_q + CNT_W'(1) == target);
						state_q      <= S_RES;
					end
				end
				S_RES: begin
					if (out_load) begin
						if (commit_q) placed_q <= placed_q + CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tuser  <= res_status_q;
				m_tlast  <= res_done_q;
				m_tdata  <= {6'd0, res_pos_q.z, res_pos_q.y, res_pos_q.x, res_index_q};
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	a_placed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		placed_q <= CNT_W'(MAX_SPHERES))
		else $error("placed count beyond capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_q < placed_q)
		else $error("scan past stored spheres");

	a_cordic_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_vld |-> state_q == S_WAIT)
		else $error("CORDIC result outside wait");

	a_done_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == ST_ACCEPT)
		else $error("chain done without acceptance");

	a_commit_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && commit_q |-> res_status_q == ST_ACCEPT && placed_q < target)
		else $error("store write on a non-accepted candidate");

endmodule

// File: bench/self_avoiding_chain_growth_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_avoiding_chain_growth_unit_test
// Stream testbench of the hard-sphere chain growth unit. A scoreboard class
// predicts every result transaction from the accepted inputs, with its own
// CORDIC, placement and overlap search, and checks each output field in
// order. Directed starts, steps and register corners come first, then random
// chains under changing register settings, with random idling on both sides
// and one long receiver hold.
// ----------------------------------------------------------------------------
module self_avoiding_chain_growth_unit_test;
	import sacg_pkg::*;

	typedef struct {
		status_t   status;
		bit [9:0]  index;
		bit [31:0] x;
		bit [31:0] y;
		bit [31:0] z;
		bit        done;
	} chain_result_t;

	class chain_scoreboard;
		bit [31:0]     sx[MAX_SPHERES];
		bit [31:0]     sy[MAX_SPHERES];
		bit [31:0]     sz[MAX_SPHERES];
		int            placed;
		longint        bond;
		longint        radius;
		int            clen;
		chain_result_t pending[$];
		int            errors;
		longint        atan_tab[CORDIC_STEPS] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430};

		function new();
			placed = 0;
			bond = 65536;
			radius = 65536;
			clen = 1023;
			errors = 0;
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		function void set_register(reg_index_t r, bit [31:0] v);
			case (r)
				REG_BOND:   bond = v[20:0];
				REG_RADIUS: radius = v[20:0];
				REG_CHAIN:  clen = v[9:0];
				default: ;
			endcase
		endfunction

		function void sin_cos(bit [31:0] ang, output longint c, output longint s);
			int     a32;
			longint z, x, y, xs, ys;
			bit     flip;
			a32 = ang;
			z = a32;
			x = CORDIC_GAIN;
			y = 0;
			flip = 0;
			if (z > 64'sd1073741824) begin
				z -= 64'sd2147483648;
				flip = 1;
			end else if (z < -64'sd1073741824) begin
				z += 64'sd2147483648;
				flip = 1;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_tab[i];
				end else begin
					x += ys; y -= xs; z += atan_tab[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function bit collides(bit [31:0] cx, bit [31:0] cy, bit [31:0] cz);
			longint ax, ay, az;
			longint r2;
			bit     hit;
			r2 = radius * radius;
			hit = 0;
			for (int j = 0; j < placed; j++) begin
				ax = longint'(int'(sx[j])) - longint'(int'(cx));
				ay = longint'(int'(sy[j])) - longint'(int'(cy));
				az = longint'(int'(sz[j])) - longint'(int'(cz));
				if (ax < 0) ax = -ax;
				if (ay < 0) ay = -ay;
				if (az < 0) az = -az;
				if (ax >= (64'sd1 << 21) || ay >= (64'sd1 << 21) || az >= (64'sd1 << 21))
					continue;
				if (r2 > ax * ax + ay * ay + az * az)
					hit = 1;
			end
			return hit;
		endfunction

		function void note_input(opcode_t op, bit [15:0] az, bit [15:0] pol,
				bit [15:0] px, bit [15:0] py, bit [15:0] pz);
			chain_result_t r;
			int            target;
			longint        ct, st, cp, sp, ux, uy, dx, dy, dz;
			int            last;
			target = (clen + 1 > MAX_SPHERES) ? MAX_SPHERES : clen + 1;
			r = '{ST_REFUSE, 10'd0, 32'd0, 32'd0, 32'd0, 1'b0};
			if (op == OP_START) begin
				sx[0] = px; sy[0] = py; sz[0] = pz;
				placed = 1;
				r = '{ST_ACCEPT, 10'd0, {16'd0, px}, {16'd0, py}, {16'd0, pz}, target == 1};
			end else if (placed != 0 && placed < target) begin
				last = placed - 1;
				sin_cos({az, 16'd0}, ct, st);
				sin_cos({1'b0, pol, 15'd0}, cp, sp);
				ux = (sp * ct) >>> 30;
				uy = (sp * st) >>> 30;
				dx = (bond * ux) >>> 30;
				dy = (bond * uy) >>> 30;
				dz = (bond * cp) >>> 30;
				r.index = placed[9:0];
				r.x = sx[last] + dx[31:0];
				r.y = sy[last] + dy[31:0];
				r.z = sz[last] + dz[31:0];
				if (collides(r.x, r.y, r.z)) begin
					r.status = ST_REJECT;
				end else begin
					sx[placed] = r.x; sy[placed] = r.y; sz[placed] = r.z;
					placed++;
					r.status = ST_ACCEPT;
					r.done = (placed == target);
				end
			end
			pending = {pending, r};
		endfunction

		task check_result(bit [1:0] st, bit [9:0] idx, bit [31:0] x, bit [31:0] y,
				bit [31:0] z, bit done);
			chain_result_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction, status", st, -1);
				return;
			end
			e = pending.pop_front();
			if (st != e.status) report("status", st, e.status);
			if (idx != e.index) report("sphere_index", idx, e.index);
			if (x != e.x) report("pos_x", int'(x), int'(e.x));
			if (y != e.y) report("pos_y", int'(y), int'(e.y));
			if (z != e.z) report("pos_z", int'(z), int'(e.z));
			if (done != e.done) report("chain_done", done, e.done);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [79:0]  s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	chain_scoreboard sb;
	int              sent_total;
	bit              quiet;
	bit              pressed;
	int              hold;

	self_avoiding_chain_growth_unit dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[9:0], m_tdata[41:10], m_tdata[73:42],
				m_tdata[105:74], m_tlast);

	initial begin
		m_tready = 0;
		pressed = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else if (!pressed && sent_total >= 150) begin
				pressed = 1;
				hold = 400;
				m_tready <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 14);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task send_item(opcode_t op, bit [15:0] az, bit [15:0] pol,
			bit [15:0] px, bit [15:0] py, bit [15:0] pz);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {pz, py, px, pol, az};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, az, pol, px, py, pz);
		sent_total++;
		quiet = sent_total >= 490;
	endtask

	task drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_register(reg_index_t r, bit [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_register(r, v);
	endtask

	task configure(bit [31:0] b, bit [31:0] r, bit [31:0] c);
		drain();
		write_register(REG_BOND, b);
		write_register(REG_RADIUS, r);
		write_register(REG_CHAIN, c);
	endtask

	task random_step();
		send_item(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	task random_start();
		send_item(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	initial begin
		bit [31:0] b, r, c;
		int        n;
		sb = new();
		sent_total = 0;
		quiet = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_START;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(OP_STEP, 16'h1234, 16'h4321, 0, 0, 0);
		send_item(OP_START, 0, 0, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_STEP, 16'h0000, 16'h0000, 0, 0, 0);
		send_item(OP_STEP, 16'h0000, 16'hFFFF, 0, 0, 0);
		send_item(OP_STEP, 16'h4000, 16'h8000, 0, 0, 0);
		send_item(OP_STEP, 16'h8000, 16'h8000, 0, 0, 0);
		send_item(OP_STEP, 16'hC000, 16'h8000, 0, 0, 0);
		send_item(OP_STEP, 16'hFFFF, 16'h4000, 0, 0, 0);
		send_item(OP_STEP, 16'h2000, 16'hC000, 0, 0, 0);

		configure(32'h0010_0000, 32'h0, 32'd1);
		send_item(OP_START, 0, 0, 16'h8000, 16'h0001, 16'h7FFF);
		send_item(OP_STEP, 16'h1000, 16'h1000, 0, 0, 0);

		configure(32'h0, 32'h0010_0000, 32'd3);
		send_item(OP_START, 0, 0, 16'h0100, 16'h0200, 16'h0300);
		send_item(OP_STEP, 16'h5555, 16'hAAAA, 0, 0, 0);

		configure(32'h0010_0000, 32'h000F_0000, 32'd2);
		send_item(OP_START, 0, 0, 16'h0, 16'h0, 16'h0);
		send_item(OP_STEP, 16'h0000, 16'h8000, 0, 0, 0);
		send_item(OP_STEP, 16'h8000, 16'h8000, 0, 0, 0);
		send_item(OP_STEP, 16'h0000, 16'h8000, 0, 0, 0);
		send_item(OP_STEP, 16'h4000, 16'h0000, 0, 0, 0);

		while (sent_total < 570) begin
			case ($urandom_range(0, 5))
				0: b = 32'h0010_0000;
				1: b = $urandom_range(0, 2) == 0 ? 0 : $urandom;
				default: b = $urandom_range(1000, 300000);
			endcase
			case ($urandom_range(0, 5))
				0: r = 32'h0010_0000;
				1: r = 0;
				2: r = $urandom;
				default: r = b[20:0] * $urandom_range(40, 99) / 100;
			endcase
			c = $urandom_range(0, 7) == 0 ? 1023 : $urandom_range(1, 40);
			if ($urandom_range(0, 3) == 0) c[31:10] = 22'($urandom);
			configure(b, r, c);
			n = $urandom_range(20, 60);
			if ($urandom_range(0, 9) != 0) random_start();
			for (int k = 0; k < n && sent_total < 570; k++)
				if ($urandom_range(0, 11) == 0) random_start();
				else random_step();
		end

		drain();
		repeat (1100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (sb.pending.size() != 0) sb.report("results left over", sb.pending.size(), 0);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/sacg_pkg.sv
hdl/sacg_cordic_cell.sv
hdl/sacg_cordic_chain.sv
hdl/self_avoiding_chain_growth_unit.sv
bench/self_avoiding_chain_growth_unit_test.sv
